/* design/keyed_device_table_unit_macros.svh */
// ----------------------------------------------------------------------------
// Keyed device table assertion macros
// Shared forms of the concurrent assertions used by the table's checker.
// ----------------------------------------------------------------------------
`ifndef KEYED_DEVICE_TABLE_UNIT_MACROS_SVH
`define KEYED_DEVICE_TABLE_UNIT_MACROS_SVH

// Checked only outside reset.
`define KDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define KDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/kdt_pkg.sv */
// ----------------------------------------------------------------------------
// Keyed device table package
// Types, codes and item layout constants shared by the table's modules.
// ----------------------------------------------------------------------------
package kdt_pkg;

  typedef enum logic [2:0] {
    OP_UPSERT     = 3'd0,
    OP_FIND_LONG  = 3'd1,
    OP_FIND_SHORT = 3'd2,
    OP_REMOVE     = 3'd3,
    OP_SET_CAPS   = 3'd4,
    OP_CLR_CAPS   = 3'd5,
    OP_ADD_ONOFF  = 3'd6
  } kdt_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_ARG   = 2'd3
  } kdt_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } kdt_state_t;

  localparam logic [7:0] ONOFF_EP_MAX = 8'd32;

  localparam int S_TDATA_W       = 120;
  localparam int M_TDATA_W       = 160;
  localparam int OUT_CHANGED_BIT = 157;

  typedef struct packed {
    logic [63:0] long_addr;
    logic [15:0] net_addr;
    logic [7:0]  endpoint;
    logic [31:0] caps;
    logic [31:0] onoff;
  } kdt_entry_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] long_addr;
    logic [15:0] net_addr;
    logic [7:0]  endpoint;
    logic [31:0] cap_bits;
  } kdt_req_t;

  typedef struct packed {
    logic hit;
    logic free_ok;
  } kdt_match_t;

  typedef struct packed {
    kdt_status_t status;
    logic        sel_free;
    logic        slot_zero;
    logic        data_zero;
    logic        wr_en;
    logic        set_valid;
    logic        clr_valid;
    logic        changed;
  } kdt_upd_t;

endpackage

/* design/keyed_device_table_unit.sv */
// ----------------------------------------------------------------------------
// Keyed device table unit
// Fully associative table of device entries keyed by a 64-bit long address.
// ----------------------------------------------------------------------------
// The s_ channel carries one request item: an operation code in s_tuser and
// the long address, short address, endpoint and capability bits in s_tdata.
// Each request yields exactly one result item on the m_ channel: the status
// in m_tuser and the slot, the entry contents and the changed flag in m_tdata.
// A request scans every slot of the entry RAM, one slot per cycle through a
// single comparator, and the result item is registered once the scan has
// passed the drain and decide states; an undefined operation code skips the
// scan and goes from acceptance straight to the decide state. s_tready is
// high only while no request is in work, so a new request is not taken
// before the last one has left the decide state.
// The result is held in an output register; while the receiver stalls it
// stays stable, and a following request is still accepted and scanned but
// waits at the end of its scan until the register is free.
// Reset clears every valid flag, so the table starts empty; entry contents
// need no clearing, as a slot becomes valid only when it is written in full.
// ----------------------------------------------------------------------------
module keyed_device_table_unit #(
  parameter int SLOTS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // long_addr[63:0], net_addr[79:64], endpoint[87:80], cap_bits[119:88]
  input  logic [kdt_pkg::S_TDATA_W-1:0]   s_tdata,
  // op[2:0]
  input  logic [2:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // slot[4:0], entry_long_addr[68:5], entry_net_addr[84:69],
  // entry_endpoint[92:85], entry_caps[124:93], entry_onoff_mask[156:125],
  // changed[157], zero fill[159:158]
  output logic [kdt_pkg::M_TDATA_W-1:0]   m_tdata,
  // status[1:0]
  output logic [1:0]                      m_tuser
);

  localparam int SW = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  kdt_pkg::kdt_state_t state, state_next;
  kdt_pkg::kdt_req_t   req;
  kdt_pkg::kdt_match_t flags;
  kdt_pkg::kdt_entry_t rd_data;
  kdt_pkg::kdt_entry_t hit_entry;
  kdt_pkg::kdt_entry_t new_entry;
  kdt_pkg::kdt_entry_t out_entry;
  kdt_pkg::kdt_upd_t   upd;

  logic [SW-1:0]    cnt;
  logic [SW-1:0]    hit_slot;
  logic [SW-1:0]    free_slot;
  logic [SW-1:0]    upd_slot;
  logic [SW+4:0]    slot_ext;
  logic [4:0]       slot_out;
  logic [SLOTS-1:0] valid;
  logic             start;
  logic             rd_en;
  logic             load;

  always_comb begin
    state_next = state;
    unique case (state)
      kdt_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser > kdt_pkg::OP_ADD_ONOFF) ? kdt_pkg::S_DECIDE
                                                         : kdt_pkg::S_SCAN;
        end
      end
      kdt_pkg::S_SCAN: begin
        if (cnt == LAST_SLOT) begin
          state_next = kdt_pkg::S_DRAIN;
        end
      end
      kdt_pkg::S_DRAIN: begin
        state_next = kdt_pkg::S_DECIDE;
      end
      kdt_pkg::S_DECIDE: begin
        if (!m_tvalid || m_tready) begin
          state_next = kdt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kdt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready = state == kdt_pkg::S_IDLE;
    start    = s_tvalid && s_tready;
    rd_en    = state == kdt_pkg::S_SCAN;
    load     = (state == kdt_pkg::S_DECIDE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kdt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req.op        <= s_tuser;
      req.long_addr <= s_tdata[63:0];
      req.net_addr  <= s_tdata[79:64];
      req.endpoint  <= s_tdata[87:80];
      req.cap_bits  <= s_tdata[119:88];
      cnt           <= '0;
    end else if (rd_en) begin
      cnt <= cnt + 1'b1;
    end
  end

  kdt_ram #(
    .WIDTH ($bits(kdt_pkg::kdt_entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (load && upd.wr_en),
    .wr_addr (upd_slot),
    .wr_data (new_entry),
    .rd_en   (rd_en),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  kdt_match #(
    .SLOTS (SLOTS)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .rd_en     (rd_en),
    .rd_addr   (cnt),
    .rd_data   (rd_data),
    .valid     (valid),
    .by_short  (req.op == kdt_pkg::OP_FIND_SHORT),
    .key       (req.long_addr),
    .short_key (req.net_addr),
    .flags     (flags),
    .hit_slot  (hit_slot),
    .free_slot (free_slot),
    .hit_entry (hit_entry)
  );

  kdt_update u_update (
    .req       (req),
    .flags     (flags),
    .hit_entry (hit_entry),
    .upd       (upd),
    .entry     (new_entry)
  );

  always_comb begin
    upd_slot  = upd.sel_free ? free_slot : hit_slot;
    slot_ext  = {5'd0, upd_slot};
    slot_out  = upd.slot_zero ? 5'd0 : slot_ext[4:0];
    out_entry = upd.data_zero ? '0 : new_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        if (upd.set_valid) begin
          valid[upd_slot] <= 1'b1;
        end
        if (upd.clr_valid) begin
          valid[upd_slot] <= 1'b0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= upd.status;
      m_tdata <= {2'b00, upd.changed, out_entry.onoff, out_entry.caps,
                  out_entry.endpoint, out_entry.net_addr, out_entry.long_addr,
                  slot_out};
    end
  end

endmodule

/* design/kdt_ram.sv */
// ----------------------------------------------------------------------------
// Keyed device table RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module kdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/kdt_match.sv */
// ----------------------------------------------------------------------------
// Keyed device table match unit
// Shared comparator that sees one slot per cycle during a scan and keeps the
// lowest matching slot, its entry and the lowest free slot.
// ----------------------------------------------------------------------------
module kdt_match #(
  parameter int SLOTS = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic                                      rd_en,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  input  kdt_pkg::kdt_entry_t                       rd_data,
  input  logic [SLOTS-1:0]                          valid,
  input  logic                                      by_short,
  input  logic [63:0]                               key,
  input  logic [15:0]                               short_key,
  output kdt_pkg::kdt_match_t                       flags,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] hit_slot,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] free_slot,
  output kdt_pkg::kdt_entry_t                       hit_entry
);

  localparam int SW = SLOTS > 1 ? $clog2(SLOTS) : 1;

  logic          cmp_vld;
  logic [SW-1:0] cmp_addr;
  logic          is_match;
  logic          is_free;

  always_comb begin
    is_free  = cmp_vld && !valid[cmp_addr];
    is_match = cmp_vld && valid[cmp_addr] &&
               (by_short ? (rd_data.net_addr == short_key) : (rd_data.long_addr == key));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
      flags   <= '0;
    end else begin
      cmp_vld <= rd_en;
      if (start) begin
        flags <= '0;
      end else begin
        if (is_match && !flags.hit) begin
          flags.hit <= 1'b1;
        end
        if (is_free && !flags.free_ok) begin
          flags.free_ok <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_addr <= rd_addr;
    if (is_match && !flags.hit) begin
      hit_slot  <= cmp_addr;
      hit_entry <= rd_data;
    end
    if (is_free && !flags.free_ok) begin
      free_slot <= cmp_addr;
    end
  end

endmodule

/* design/kdt_update.sv */
// ----------------------------------------------------------------------------
// Keyed device table update logic
// Works out the status, the new entry contents and the writes of one item
// once the scan has settled.
// ----------------------------------------------------------------------------
module kdt_update (
  input  kdt_pkg::kdt_req_t   req,
  input  kdt_pkg::kdt_match_t flags,
  input  kdt_pkg::kdt_entry_t hit_entry,
  output kdt_pkg::kdt_upd_t   upd,
  output kdt_pkg::kdt_entry_t entry
);

  logic [7:0]  ep_m1;
  logic [31:0] ep_bit;
  logic        ep_ok;

  always_comb begin
    ep_m1  = req.endpoint - 8'd1;
    ep_bit = 32'd1 << ep_m1[4:0];
    ep_ok  = (req.endpoint != 8'd0) && (req.endpoint <= kdt_pkg::ONOFF_EP_MAX);
  end

  always_comb begin
    upd        = '0;
    upd.status = kdt_pkg::ST_OK;
    entry      = hit_entry;
    case (req.op) inside
      kdt_pkg::OP_FIND_SHORT: begin
        if (!flags.hit) begin
          upd.status    = kdt_pkg::ST_NOT_FOUND;
          upd.slot_zero = 1'b1;
          upd.data_zero = 1'b1;
        end
      end
      kdt_pkg::OP_UPSERT: begin
        if (flags.hit) begin
          entry.net_addr = req.net_addr;
          if (req.endpoint != 8'd0) begin
            entry.endpoint = req.endpoint;
          end
          upd.wr_en = 1'b1;
        end else if (flags.free_ok) begin
          entry.long_addr = req.long_addr;
          entry.net_addr  = req.net_addr;
          entry.endpoint  = req.endpoint;
          entry.caps      = '0;
          entry.onoff     = '0;
          upd.sel_free    = 1'b1;
          upd.set_valid   = 1'b1;
          upd.wr_en       = 1'b1;
        end else begin
          upd.status    = kdt_pkg::ST_FULL;
          upd.slot_zero = 1'b1;
          upd.data_zero = 1'b1;
        end
      end
      kdt_pkg::OP_FIND_LONG, kdt_pkg::OP_REMOVE, kdt_pkg::OP_SET_CAPS,
      kdt_pkg::OP_CLR_CAPS, kdt_pkg::OP_ADD_ONOFF: begin
        if (!flags.hit) begin
          upd.status    = kdt_pkg::ST_NOT_FOUND;
          upd.slot_zero = 1'b1;
          upd.data_zero = 1'b1;
        end else begin
          case (req.op) inside
            kdt_pkg::OP_REMOVE: begin
              upd.clr_valid = 1'b1;
              upd.data_zero = 1'b1;
            end
            kdt_pkg::OP_SET_CAPS, kdt_pkg::OP_CLR_CAPS: begin
              if (req.cap_bits == 32'd0) begin
                upd.status = kdt_pkg::ST_BAD_ARG;
              end else begin
                if (req.op == kdt_pkg::OP_SET_CAPS) begin
                  entry.caps = hit_entry.caps | req.cap_bits;
                end else begin
                  entry.caps = hit_entry.caps & ~req.cap_bits;
                end
                upd.changed = entry.caps != hit_entry.caps;
                upd.wr_en   = 1'b1;
              end
            end
            kdt_pkg::OP_ADD_ONOFF: begin
              if (!ep_ok) begin
                upd.status = kdt_pkg::ST_BAD_ARG;
              end else begin
                entry.onoff = hit_entry.onoff | ep_bit;
                if (hit_entry.endpoint == 8'd0 || req.endpoint == 8'd1 ||
                    (hit_entry.endpoint != 8'd1 && req.endpoint < hit_entry.endpoint)) begin
                  entry.endpoint = req.endpoint;
                end
                upd.changed = entry.onoff != hit_entry.onoff;
                upd.wr_en   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        upd.status    = kdt_pkg::ST_BAD_ARG;
        upd.slot_zero = 1'b1;
        upd.data_zero = 1'b1;
      end
    endcase
  end

endmodule

/* design/kdt_checker.sv */
// ----------------------------------------------------------------------------
// Keyed device table checker
// Port level assertions on the table's request and result channels.
// ----------------------------------------------------------------------------
`include "keyed_device_table_unit_macros.svh"

module kdt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [2:0]                    s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [kdt_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [1:0]                    m_tuser
);

  `KDT_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid right after reset")

  `KDT_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

  `KDT_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  `KDT_ASSERT(a_miss_zero, m_tvalid && (m_tuser == kdt_pkg::ST_NOT_FOUND || m_tuser == kdt_pkg::ST_FULL) |-> m_tdata == '0, "miss or full result carries data")

  `KDT_ASSERT(a_changed_ok_only, m_tvalid && m_tuser != kdt_pkg::ST_OK |-> !m_tdata[kdt_pkg::OUT_CHANGED_BIT], "changed set on a failed item")

endmodule

bind keyed_device_table_unit kdt_checker u_kdt_checker (.*);
